// ===== rtl/core/handle_table_allocator_defines.svh =====
// assertion macros for the handle table allocator
// used by the controller and the datapath; assumes clk_i and rst_ni in scope
`ifndef HANDLE_TABLE_ALLOCATOR_DEFINES_SVH
`define HANDLE_TABLE_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define HTA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define HTA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HTA_ASSERT(name, prop, msg)
`define HTA_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

// ===== rtl/core/hta_pkg.sv =====
// shared types for the handle table allocator
// item structs, action and status codes, controller commands; no dependencies
package hta_pkg;

  typedef enum logic [1:0] {
    ACT_ADD_AUTO = 2'd0,
    ACT_ADD_AT   = 2'd1,
    ACT_DELETE   = 2'd2,
    ACT_FIND     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_OCCUPIED = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_e;

  localparam int HandleBits = 8;
  localparam int WordBits   = 32;
  localparam int HandleSpace = 1 << HandleBits;
  localparam int GroupBits  = 16;
  localparam int NumGroups  = HandleSpace / GroupBits;

  typedef struct packed {
    action_e               action;
    logic [HandleBits-1:0] handle;
    logic [WordBits-1:0]   value;
  } in_item_t;

  typedef struct packed {
    logic [HandleBits-1:0] result_handle;
    logic [WordBits-1:0]   result_value;
    status_e               status;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic commit;
  } cmd_t;

endpackage

// ===== rtl/core/hta_ctrl.sv =====
// controller for the handle table allocator
// two-state sequencer and output valid flag; uses hta_pkg and the defines header
`include "handle_table_allocator_defines.svh"

module hta_ctrl (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output hta_pkg::cmd_t cmd_o
);
  import hta_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  cmd_t   cmd;

  always_comb begin
    cmd.load   = (state_q == ST_IDLE) && in_valid_i;
    cmd.commit = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    unique case (state_q)
      ST_IDLE: state_d = cmd.load ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_d = cmd.commit ? ST_IDLE : ST_EXEC;
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd.commit || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  `HTA_ASSERT_NEXT(a_load_to_exec, cmd.load, state_q == ST_EXEC, "load did not enter exec")
  `HTA_ASSERT_NEXT(a_commit_gives_item, cmd.commit, out_valid_q && state_q == ST_IDLE, "commit lost result")
  `HTA_ASSERT_NEXT(a_exec_holds, state_q == ST_EXEC && !cmd.commit, state_q == ST_EXEC, "exec left early")
  `HTA_ASSERT(a_no_overwrite, !(cmd.commit && out_valid_q && !out_ready_i), "pending result overwritten")

endmodule

// ===== rtl/core/hta_dpath.sv =====
// datapath for the handle table allocator
// occupancy bitmap, group summary, lowest-free search, value memory, result register
`include "handle_table_allocator_defines.svh"

module hta_dpath #(
  parameter int CAPACITY   = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hta_pkg::cmd_t     cmd_i,
  input  hta_pkg::in_item_t in_item_i,
  output hta_pkg::out_item_t out_item_o
);
  import hta_pkg::*;

  localparam int Usable = (CAPACITY < HandleSpace) ? CAPACITY : HandleSpace;
  localparam int AddrBits = $clog2(Usable);
  localparam logic [HandleBits:0] UsableLimit = (HandleBits + 1)'(Usable);

  in_item_t                  req_q;
  logic [Usable-1:0]         bitmap_q;
  logic [HandleSpace-1:0]    occ_pad;
  logic [NumGroups-1:0]      group_free_q;
  logic [VALUE_BITS-1:0]     mem [Usable];
  logic [VALUE_BITS-1:0]     rd_q;
  logic [VALUE_BITS-1:0]     wdata;
  out_item_t                 out_q;
  out_item_t                 res_d;

  logic [3:0]                first_grp;
  logic [3:0]                first_bit;
  logic [GroupBits-1:0]      grp_bits;
  logic [HandleBits-1:0]     free_slot;
  logic                      any_free;
  logic                      in_range;
  logic                      occ_bit;
  logic [HandleBits-1:0]     tgt;
  logic [AddrBits-1:0]       widx;
  logic                      set_en;
  logic                      clr_en;
  logic [WordBits-1:0]       rd_word;

  // slots past the usable range read as taken
  always_comb begin
    occ_pad = '1;
    occ_pad[Usable-1:0] = bitmap_q;
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < NumGroups; g++) begin
      group_free_q[g] <= ~&occ_pad[g*GroupBits +: GroupBits];
    end
  end

  // lowest free group, then lowest free bit in it
  always_comb begin
    first_grp = '0;
    for (int g = NumGroups - 1; g >= 0; g--) begin
      if (group_free_q[g]) begin
        first_grp = 4'(g);
      end
    end
    any_free = |group_free_q;
    grp_bits = occ_pad[{first_grp, 4'b0000} +: GroupBits];
    first_bit = '0;
    for (int b = GroupBits - 1; b >= 0; b--) begin
      if (!grp_bits[b]) begin
        first_bit = 4'(b);
      end
    end
    free_slot = {first_grp, first_bit};
  end

  assign in_range = {1'b0, req_q.handle} < UsableLimit;
  assign occ_bit  = in_range && occ_pad[req_q.handle];
  assign wdata    = VALUE_BITS'({32'b0, req_q.value});
  assign rd_word  = 32'(64'(rd_q));

  always_comb begin
    res_d.result_handle = req_q.handle;
    res_d.result_value  = '0;
    res_d.status        = STAT_OK;
    set_en = 1'b0;
    clr_en = 1'b0;
    tgt    = req_q.handle;
    unique case (req_q.action)
      ACT_ADD_AUTO: begin
        tgt = free_slot;
        if (any_free) begin
          set_en = 1'b1;
          res_d.result_handle = free_slot;
        end else begin
          res_d.result_handle = '0;
          res_d.status = STAT_FULL;
        end
      end
      ACT_ADD_AT: begin
        if (!in_range) begin
          res_d.status = STAT_FULL;
        end else if (occ_bit) begin
          res_d.status = STAT_OCCUPIED;
        end else begin
          set_en = 1'b1;
        end
      end
      ACT_DELETE: begin
        clr_en = in_range;
      end
      ACT_FIND: begin
        if (occ_bit) begin
          res_d.result_value = rd_word;
        end else begin
          res_d.status = STAT_EMPTY;
        end
      end
      default: begin
        res_d.status = STAT_OK;
      end
    endcase
  end

  assign widx = tgt[AddrBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bitmap_q <= '0;
    end else if (cmd_i.commit) begin
      if (set_en) begin
        bitmap_q[widx] <= 1'b1;
      end else if (clr_en) begin
        bitmap_q[widx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && set_en) begin
      mem[widx] <= wdata;
    end
    if (cmd_i.load) begin
      rd_q <= mem[in_item_i.handle[AddrBits-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_item_i;
    end
    if (cmd_i.commit) begin
      out_q <= res_d;
    end
  end

  assign out_item_o = out_q;

  `HTA_ASSERT_NEXT(a_auto_sets_slot, cmd_i.commit && req_q.action == ACT_ADD_AUTO && any_free, occ_pad[$past(free_slot)], "auto add did not take slot")
  `HTA_ASSERT(a_free_slot_clear, !(cmd_i.commit && any_free && occ_pad[free_slot]), "search picked a taken slot")
  `HTA_ASSERT(a_full_is_full, !(cmd_i.commit && req_q.action == ACT_ADD_AUTO && !any_free && !(&occ_pad)), "full reported with free slot")

endmodule

// ===== rtl/core/handle_table_allocator.sv =====
// handle table allocator top level
// joins hta_ctrl and hta_dpath; uses hta_pkg
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o   | in_item_i  (action, handle, value)
//   out     | output    | out_valid_o / out_ready_i | out_item_o (result_handle, result_value, status)
//
// each item first registers the request and reads the value memory,
// then does the two-level lowest-free search and the bitmap and memory update
// the result sits in an output register; the next item is taken while it waits
// the search and update step stalls only while an earlier result is still untaken
// reset empties the bitmap at once; the value memory is not cleared
module handle_table_allocator #(
  parameter int CAPACITY   = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hta_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hta_pkg::out_item_t out_item_o
);
  import hta_pkg::*;

  cmd_t cmd;

  hta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  hta_dpath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

endmodule
